// ===== hdl/rsib_pkg.sv =====
package rsib_pkg;

    localparam logic [1:0] OP_SLEEP       = 2'd0;
    localparam logic [1:0] OP_ARM_BACKOFF = 2'd1;
    localparam logic [1:0] OP_ARM_DELAY   = 2'd2;

    localparam logic [1:0] LED_NORMAL = 2'd0;
    localparam logic [1:0] LED_FAST   = 2'd1;
    localparam logic [1:0] LED_SLOW   = 2'd2;

    localparam logic [1:0] CFG_BASE_SLEEP       = 2'd0;
    localparam logic [1:0] CFG_COLLISION_ROUNDS = 2'd1;
    localparam logic [1:0] CFG_SPECIAL_FRAME    = 2'd2;

    localparam logic [15:0] BASE_SLEEP_RST       = 16'd1000;
    localparam logic [7:0]  COLLISION_ROUNDS_RST = 8'd8;
    localparam logic [15:0] SPECIAL_FRAME_RST    = 16'd0;

    localparam logic [31:0] LCG_MUL  = 32'd1103515245;
    localparam logic [31:0] LCG_ADD  = 32'd12345;
    localparam logic [31:0] RAND_MOD = 32'd2147483647;

    localparam logic [9:0] SPAN_NARROW = 10'd465;
    localparam logic [9:0] SPAN_WIDE   = 10'd701;
    localparam logic [9:0] LO_NARROW   = 10'd36;
    localparam logic [9:0] LO_WIDE     = 10'd100;

    localparam int RECIP_SHIFT = 40;
    localparam int QUOT_W      = 23;
    localparam logic [31:0] RECIP_NARROW = 32'((64'd1 << RECIP_SHIFT) / 64'd465);
    localparam logic [31:0] RECIP_WIDE   = 32'((64'd1 << RECIP_SHIFT) / 64'd701);

    localparam logic [23:0] FRAME_EXTRA      = 24'd300;
    localparam logic [23:0] FAST_BLINK_COUNT = 24'd100;
    localparam logic [23:0] SLOW_BLINK_COUNT = 24'd1000;
    localparam logic [23:0] LONG_LIMIT       = 24'd624450;
    localparam logic [19:0] LONG_LOAD        = 20'd8326;
    localparam logic [19:0] SHORT_LIMIT      = 20'd5;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  led_status;
        logic        special_mode;
        logic [15:0] random_seed;
        logic [23:0] load_value;
    } t_req;

    typedef struct packed {
        logic [20:0] timer_count;
        logic        long_sleep;
        logic [31:0] long_sleep_total;
    } t_res;

    typedef struct packed {
        logic [1:0]  addr;
        logic [15:0] wdata;
    } t_cfg;

    typedef struct packed {
        logic        draw;
        logic        wide;
        logic [15:0] seed;
        logic [23:0] base_cnt;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== hdl/rsib_chan_if.sv =====
interface rsib_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/randomized_sleep_interval_backoff_unit.sv =====
// Wake-timer load calculator for a sleeping radio tag.
// Requests arrive on i_req. A sleep request yields one result on o_res with the
// doubled timer count, the long-sleep flag and, for a long sleep, the count before replacement.
// Arm-backoff and arm-delay requests only update internal state and yield no result.
// Registers are written through i_cfg, which is always ready; write only while the
// block holds no request in flight.
// A request is classified and the state updated in the cycle it is accepted; sleep
// requests then pass through a queue of QUEUE_DEPTH entries into a six-register
// pipeline that does the random draw: LCG multiply, fold modulo 2^31-1, reciprocal
// multiply, remainder, range offset and final limits.
// Throughput is one request per cycle while o_res is not stalled.
// When o_res is stalled the pipeline holds, the queue fills, and i_req.ready drops
// once QUEUE_DEPTH requests are waiting.
// Reset clears the queue, the pipeline and the backoff and delay state, and loads
// the registers with their defaults.
module randomized_sleep_interval_backoff_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsib_chan_if.sink   i_req,
    rsib_chan_if.sink   i_cfg,
    rsib_chan_if.source o_res
);

    rsib_pkg::t_push  w_push;
    rsib_pkg::t_job   w_job;
    rsib_pkg::t_qstat w_qstat;
    logic             w_pop;
    logic [15:0]      w_base_sleep;

    rsib_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_cfg        (i_cfg),
        .i_q_full     (w_qstat.full),
        .o_push       (w_push),
        .o_base_sleep (w_base_sleep)
    );

    rsib_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_job   (w_job),
        .o_qstat (w_qstat)
    );

    rsib_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (w_job),
        .i_q_empty    (w_qstat.empty),
        .o_pop        (w_pop),
        .i_base_sleep (w_base_sleep),
        .o_res        (o_res)
    );

`ifndef SYNTHESIS
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> !w_qstat.full)
        else $error("Queue written while full.");

    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("Queue read while empty.");

    a_long_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.long_sleep |->
            o_res.data.timer_count == {rsib_pkg::LONG_LOAD, 1'b0} &&
            o_res.data.long_sleep_total > {8'd0, rsib_pkg::LONG_LIMIT})
        else $error("Long-sleep result carries a wrong count.");

    a_short_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.data.long_sleep |-> o_res.data.long_sleep_total == 32'd0)
        else $error("Total reported without long sleep.");
`endif

endmodule

// ===== hdl/rsib_front.sv =====
module rsib_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rsib_chan_if.sink         i_req,
    rsib_chan_if.sink         i_cfg,
    input  logic              i_q_full,
    output rsib_pkg::t_push   o_push,
    output logic [15:0]       o_base_sleep
);

    logic        r_backoff_active, n_backoff_active;
    logic [7:0]  r_rounds_done, n_rounds_done;
    logic [23:0] r_backoff_timer, n_backoff_timer;
    logic        r_delay_pending, n_delay_pending;
    logic [23:0] r_delay_margin, n_delay_margin;
    logic [15:0] r_base_sleep, n_base_sleep;
    logic [7:0]  r_collision_rounds, n_collision_rounds;
    logic [15:0] r_special_frame, n_special_frame;

    logic        w_accept;
    logic [7:0]  w_rounds_inc;
    logic [23:0] w_timer_half;

    assign i_req.ready  = !i_q_full;
    assign i_cfg.ready  = 1'b1;
    assign w_accept     = i_req.valid && i_req.ready;
    assign w_rounds_inc = r_rounds_done + 8'd1;
    assign w_timer_half = {1'b0, r_backoff_timer[23:1]};
    assign o_base_sleep = r_base_sleep;

    always_comb begin
        n_backoff_active   = r_backoff_active;
        n_rounds_done      = r_rounds_done;
        n_backoff_timer    = r_backoff_timer;
        n_delay_pending    = r_delay_pending;
        n_delay_margin     = r_delay_margin;
        n_base_sleep       = r_base_sleep;
        n_collision_rounds = r_collision_rounds;
        n_special_frame    = r_special_frame;
        o_push             = '0;
        o_push.job.seed    = i_req.data.random_seed;

        if (i_cfg.valid) begin
            case (i_cfg.data.addr)
                rsib_pkg::CFG_BASE_SLEEP: begin
                    n_base_sleep = i_cfg.data.wdata;
                end
                rsib_pkg::CFG_COLLISION_ROUNDS: begin
                    n_collision_rounds = i_cfg.data.wdata[7:0];
                end
                rsib_pkg::CFG_SPECIAL_FRAME: begin
                    n_special_frame = i_cfg.data.wdata;
                end
                default: begin
                end
            endcase
        end

        if (w_accept) begin
            case (i_req.data.op)
                rsib_pkg::OP_ARM_BACKOFF: begin
                    n_backoff_active = 1'b1;
                    n_backoff_timer  = i_req.data.load_value;
                    n_rounds_done    = 8'd0;
                end
                rsib_pkg::OP_ARM_DELAY: begin
                    n_delay_pending = 1'b1;
                    n_delay_margin  = i_req.data.load_value;
                end
                rsib_pkg::OP_SLEEP: begin
                    o_push.valid = 1'b1;
                    case (i_req.data.led_status)
                        rsib_pkg::LED_NORMAL: begin
                            if (r_backoff_active) begin
                                if (w_rounds_inc > r_collision_rounds) begin
                                    n_backoff_active = 1'b0;
                                    n_rounds_done    = 8'd0;
                                    n_backoff_timer  = {8'd0, r_base_sleep}
                                                       + rsib_pkg::FRAME_EXTRA;
                                end else begin
                                    n_rounds_done       = w_rounds_inc;
                                    n_backoff_timer     = w_timer_half;
                                    o_push.job.draw     = 1'b1;
                                    o_push.job.wide     = 1'b1;
                                    o_push.job.base_cnt = w_timer_half;
                                end
                            end else if (i_req.data.special_mode) begin
                                o_push.job.base_cnt = {8'd0, r_special_frame}
                                                      + rsib_pkg::FRAME_EXTRA;
                            end else if (r_delay_pending) begin
                                n_delay_pending     = 1'b0;
                                o_push.job.base_cnt = r_delay_margin;
                            end else begin
                                o_push.job.draw     = 1'b1;
                                o_push.job.base_cnt = {8'd0, r_base_sleep};
                            end
                        end
                        rsib_pkg::LED_FAST: begin
                            o_push.job.base_cnt = rsib_pkg::FAST_BLINK_COUNT;
                        end
                        rsib_pkg::LED_SLOW: begin
                            o_push.job.base_cnt = rsib_pkg::SLOW_BLINK_COUNT;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backoff_active   <= 1'b0;
            r_rounds_done      <= 8'd0;
            r_backoff_timer    <= 24'd0;
            r_delay_pending    <= 1'b0;
            r_delay_margin     <= 24'd0;
            r_base_sleep       <= rsib_pkg::BASE_SLEEP_RST;
            r_collision_rounds <= rsib_pkg::COLLISION_ROUNDS_RST;
            r_special_frame    <= rsib_pkg::SPECIAL_FRAME_RST;
        end else begin
            r_backoff_active   <= n_backoff_active;
            r_rounds_done      <= n_rounds_done;
            r_backoff_timer    <= n_backoff_timer;
            r_delay_pending    <= n_delay_pending;
            r_delay_margin     <= n_delay_margin;
            r_base_sleep       <= n_base_sleep;
            r_collision_rounds <= n_collision_rounds;
            r_special_frame    <= n_special_frame;
        end
    end

endmodule

// ===== hdl/rsib_queue.sv =====
module rsib_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rsib_pkg::t_push  i_push,
    input  logic             i_pop,
    output rsib_pkg::t_job   o_job,
    output rsib_pkg::t_qstat o_qstat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rsib_pkg::t_job r_mem [DEPTH];
    rsib_pkg::t_job r_head;
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;

    assign o_job         = r_head;
    assign o_qstat.full  = (r_count == CW'(DEPTH));
    assign o_qstat.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push.valid && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // The head register tracks the entry at the next read pointer, taking a request
    // that is written to that entry in the same cycle straight from the input.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
        if (i_push.valid && (r_wr_ptr == n_rd_ptr)) begin
            r_head <= i_push.job;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

endmodule

// ===== hdl/rsib_back.sv =====
module rsib_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rsib_pkg::t_job i_job,
    input  logic           i_q_empty,
    output logic           o_pop,
    input  logic [15:0]    i_base_sleep,
    rsib_chan_if.source    o_res
);

    typedef struct packed {
        logic        draw;
        logic        wide;
        logic [23:0] base_cnt;
    } t_tail;

    logic w_adv;

    logic        r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid, r_out_valid;
    t_tail       r_s1_tail, r_s2_tail, r_s3_tail, r_s4_tail;
    logic [31:0] r_s1_x;
    logic [30:0] r_s2_y, r_s3_y;
    logic [rsib_pkg::QUOT_W-1:0] r_s3_q;
    logic [10:0] r_s4_rem;
    logic [23:0] r_s5_cnt;
    rsib_pkg::t_res r_out, n_out;

    logic [31:0] n_s1_x;
    logic [31:0] w_fold;
    logic [30:0] n_s2_y;
    logic [31:0] w_recip;
    logic [62:0] w_prod;
    logic [9:0]  w_span3, w_span4;
    logic [31:0] w_qd;
    logic [31:0] w_rem0;
    logic [10:0] w_rem_full;
    logic [9:0]  w_rem;
    logic [9:0]  w_draw;
    logic [23:0] n_s5_cnt;
    logic        w_long;
    logic [19:0] w_cnt;

    assign w_adv = !r_out_valid || o_res.ready;
    assign o_pop = w_adv && !i_q_empty;

    assign n_s1_x = 32'({16'd0, i_job.seed} * rsib_pkg::LCG_MUL + rsib_pkg::LCG_ADD);

    assign w_fold = {1'b0, r_s1_x[30:0]} + {31'd0, r_s1_x[31]};
    assign n_s2_y = (w_fold >= rsib_pkg::RAND_MOD) ? 31'(w_fold - rsib_pkg::RAND_MOD)
                                                   : w_fold[30:0];

    assign w_recip = r_s2_tail.wide ? rsib_pkg::RECIP_WIDE : rsib_pkg::RECIP_NARROW;
    assign w_prod  = {32'd0, r_s2_y} * {31'd0, w_recip};

    assign w_span3 = r_s3_tail.wide ? rsib_pkg::SPAN_WIDE : rsib_pkg::SPAN_NARROW;
    assign w_qd    = {9'd0, r_s3_q} * {22'd0, w_span3};
    assign w_rem0  = {1'b0, r_s3_y} - w_qd;

    assign w_span4    = r_s4_tail.wide ? rsib_pkg::SPAN_WIDE : rsib_pkg::SPAN_NARROW;
    assign w_rem_full = (r_s4_rem >= {1'b0, w_span4}) ? r_s4_rem - {1'b0, w_span4} : r_s4_rem;
    assign w_rem      = w_rem_full[9:0];
    assign w_draw     = w_rem + (r_s4_tail.wide ? rsib_pkg::LO_WIDE : rsib_pkg::LO_NARROW);
    assign n_s5_cnt   = r_s4_tail.base_cnt + (r_s4_tail.draw ? {14'd0, w_draw} : 24'd0);

    always_comb begin
        w_long = (r_s5_cnt > rsib_pkg::LONG_LIMIT);
        w_cnt  = w_long ? rsib_pkg::LONG_LOAD : r_s5_cnt[19:0];
        if (w_cnt <= rsib_pkg::SHORT_LIMIT) begin
            w_cnt = {4'd0, i_base_sleep};
        end
        n_out.timer_count      = {w_cnt, 1'b0};
        n_out.long_sleep       = w_long;
        n_out.long_sleep_total = w_long ? {8'd0, r_s5_cnt} : 32'd0;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= o_pop;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= r_s4_valid;
            r_out_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_x             <= n_s1_x;
            r_s1_tail.draw     <= i_job.draw;
            r_s1_tail.wide     <= i_job.wide;
            r_s1_tail.base_cnt <= i_job.base_cnt;
            r_s2_y             <= n_s2_y;
            r_s2_tail          <= r_s1_tail;
            r_s3_q             <= w_prod[rsib_pkg::RECIP_SHIFT +: rsib_pkg::QUOT_W];
            r_s3_y             <= r_s2_y;
            r_s3_tail          <= r_s2_tail;
            r_s4_rem           <= w_rem0[10:0];
            r_s4_tail          <= r_s3_tail;
            r_s5_cnt           <= n_s5_cnt;
            r_out              <= n_out;
        end
    end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam logic [1:0] LED_UNDEF  = 2'd3;
    localparam int unsigned SETTLE_CYCLES = 16;

    logic i_clk;
    logic i_rst_n;

    rsib_chan_if #(.T(rsib_pkg::t_req)) req_if ();
    rsib_chan_if #(.T(rsib_pkg::t_cfg)) cfg_if ();
    rsib_chan_if #(.T(rsib_pkg::t_res)) res_if ();

    randomized_sleep_interval_backoff_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // Shadow copy of the registers and of the backoff and delay state.
    logic [15:0] cfg_base    = rsib_pkg::BASE_SLEEP_RST;
    logic [7:0]  cfg_rounds  = rsib_pkg::COLLISION_ROUNDS_RST;
    logic [15:0] cfg_special = rsib_pkg::SPECIAL_FRAME_RST;
    logic        bk_active   = 1'b0;
    logic [7:0]  bk_rounds   = '0;
    logic [31:0] bk_timer    = '0;
    logic        dly_pending = 1'b0;
    logic [31:0] dly_margin  = '0;

    rsib_pkg::t_req sleep_reqs_pending[$];
    rsib_pkg::t_res wake_loads_due[$];
    int unsigned queued_cnt   = 0;
    int unsigned mismatch_cnt = 0;

    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;
    logic [2:0]  stall_phase = '0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] lcg_pick(logic [15:0] seed, logic [9:0] lo,
                                             logic [9:0] span);
        logic [31:0] x;
        x = 32'(seed) * rsib_pkg::LCG_MUL + rsib_pkg::LCG_ADD;
        x = x % rsib_pkg::RAND_MOD;
        return x % 32'(span) + 32'(lo);
    endfunction

    function automatic void predict_wake_load(rsib_pkg::t_req r);
        logic [31:0]    cnt;
        logic [31:0]    dbl;
        rsib_pkg::t_res res;
        cnt = '0;
        res = '0;
        if (r.op == rsib_pkg::OP_ARM_BACKOFF) begin
            bk_active = 1'b1;
            bk_timer  = 32'(r.load_value);
            bk_rounds = '0;
        end else if (r.op == rsib_pkg::OP_ARM_DELAY) begin
            dly_pending = 1'b1;
            dly_margin  = 32'(r.load_value);
        end else if (r.op == rsib_pkg::OP_SLEEP) begin
            if (r.led_status == rsib_pkg::LED_NORMAL) begin
                if (bk_active) begin
                    bk_rounds = bk_rounds + 8'd1;
                    if (bk_rounds > cfg_rounds) begin
                        bk_active = 1'b0;
                        bk_rounds = '0;
                        bk_timer  = 32'(cfg_base) + 32'(rsib_pkg::FRAME_EXTRA);
                    end else begin
                        bk_timer = bk_timer >> 1;
                        cnt = bk_timer + lcg_pick(r.random_seed, rsib_pkg::LO_WIDE,
                                                  rsib_pkg::SPAN_WIDE);
                    end
                end else if (r.special_mode) begin
                    cnt = 32'(cfg_special) + 32'(rsib_pkg::FRAME_EXTRA);
                end else if (dly_pending) begin
                    dly_pending = 1'b0;
                    cnt = dly_margin;
                    if (cnt <= 32'(rsib_pkg::SHORT_LIMIT)) begin
                        cnt = 32'(cfg_base);
                    end
                end else begin
                    cnt = 32'(cfg_base) + lcg_pick(r.random_seed, rsib_pkg::LO_NARROW,
                                                   rsib_pkg::SPAN_NARROW);
                end
            end else if (r.led_status == rsib_pkg::LED_FAST) begin
                cnt = 32'(rsib_pkg::FAST_BLINK_COUNT);
            end else if (r.led_status == rsib_pkg::LED_SLOW) begin
                cnt = 32'(rsib_pkg::SLOW_BLINK_COUNT);
            end
            if (cnt > 32'(rsib_pkg::LONG_LIMIT)) begin
                res.long_sleep       = 1'b1;
                res.long_sleep_total = cnt;
                cnt = 32'(rsib_pkg::LONG_LOAD);
            end
            if (cnt <= 32'(rsib_pkg::SHORT_LIMIT)) begin
                cnt = 32'(cfg_base);
            end
            dbl = cnt << 1;
            res.timer_count = dbl[20:0];
            wake_loads_due.push_back(res);
        end
    endfunction

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predict_wake_load(req_if.data);
            end
            if (!req_if.valid || req_if.ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    req_if.valid <= 1'b0;
                end else if (sleep_reqs_pending.size() > 0) begin
                    req_if.valid <= 1'b1;
                    req_if.data  <= sleep_reqs_pending.pop_front();
                    if (burst_left > 1) begin
                        burst_left = burst_left - 1;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with its own stall pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (wake_loads_due.size() == 0) begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= 10) begin
                        $display("unexpected result: count %0d long %0d total %0d",
                                 res_if.data.timer_count, res_if.data.long_sleep,
                                 res_if.data.long_sleep_total);
                    end
                end else begin
                    rsib_pkg::t_res exp_res;
                    exp_res = wake_loads_due.pop_front();
                    if (res_if.data.timer_count !== exp_res.timer_count
                        || res_if.data.long_sleep !== exp_res.long_sleep
                        || res_if.data.long_sleep_total !== exp_res.long_sleep_total) begin
                        mismatch_cnt = mismatch_cnt + 1;
                        if (mismatch_cnt <= 10) begin
                            $display({"mismatch: expected count %0d long %0d total %0d,",
                                      " got count %0d long %0d total %0d"},
                                     exp_res.timer_count, exp_res.long_sleep,
                                     exp_res.long_sleep_total, res_if.data.timer_count,
                                     res_if.data.long_sleep, res_if.data.long_sleep_total);
                        end
                    end
                end
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end
            stall_left  = stall_left - 1;
            stall_phase = stall_phase + 3'd1;
            case (stall_mode)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= 1'($urandom_range(0, 1));
                2: res_if.ready <= ($urandom_range(0, 3) == 0);
                default: res_if.ready <= (stall_phase != 3'd0);
            endcase
        end
    end

    function automatic void push_req(logic [1:0] op, logic [1:0] led, logic sp,
                                     logic [15:0] seed, logic [23:0] load);
        rsib_pkg::t_req r;
        r.op           = op;
        r.led_status   = led;
        r.special_mode = sp;
        r.random_seed  = seed;
        r.load_value   = load;
        sleep_reqs_pending.push_back(r);
        if (op != OP_IGNORED) begin
            queued_cnt = queued_cnt + 1;
        end
    endfunction

    function automatic logic [23:0] rand_load();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 10));
            1: return 24'($urandom_range(624440, 624460));
            2: return 24'($urandom_range(0, 2000));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic void push_sleep_mix();
        case ($urandom_range(0, 9))
            0: push_req(rsib_pkg::OP_SLEEP, 2'($urandom_range(1, 3)), 1'($urandom),
                        16'($urandom), 24'($urandom));
            1: push_req(OP_IGNORED, 2'($urandom), 1'($urandom), 16'($urandom),
                        24'($urandom));
            default: push_req(rsib_pkg::OP_SLEEP, rsib_pkg::LED_NORMAL, 1'($urandom),
                              16'($urandom), 24'($urandom));
        endcase
    endfunction

    function automatic void gen_traffic(int unsigned target);
        int unsigned goal;
        int unsigned pick;
        int unsigned max_len;
        goal = queued_cnt + target;
        while (queued_cnt < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                push_req(rsib_pkg::OP_ARM_BACKOFF, 2'($urandom), 1'($urandom),
                         16'($urandom), rand_load());
                max_len = (cfg_rounds > 8'd36) ? 40 : int'(cfg_rounds) + 4;
                repeat ($urandom_range(1, max_len)) push_sleep_mix();
            end else if (pick < 50) begin
                push_req(rsib_pkg::OP_ARM_DELAY, 2'($urandom), 1'($urandom),
                         16'($urandom), rand_load());
                repeat ($urandom_range(0, 2)) push_sleep_mix();
                push_req(rsib_pkg::OP_SLEEP, rsib_pkg::LED_NORMAL, 1'b0, 16'($urandom),
                         24'($urandom));
            end else if (pick < 70) begin
                push_req(rsib_pkg::OP_SLEEP, rsib_pkg::LED_NORMAL, 1'($urandom),
                         16'($urandom), 24'($urandom));
            end else if (pick < 85) begin
                push_req(2'($urandom), 2'($urandom), 1'($urandom), 16'($urandom),
                         24'($urandom));
            end else begin
                push_req(rsib_pkg::OP_SLEEP, 2'($urandom_range(1, 3)), 1'($urandom),
                         16'($urandom), 24'($urandom));
            end
        end
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (sleep_reqs_pending.size() != 0 || req_if.valid || wake_loads_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_setting(logic [1:0] addr, logic [15:0] value);
        @(posedge i_clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.data.addr  <= addr;
        cfg_if.data.wdata <= value;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (addr)
            rsib_pkg::CFG_BASE_SLEEP:       cfg_base    = value;
            rsib_pkg::CFG_COLLISION_ROUNDS: cfg_rounds  = value[7:0];
            rsib_pkg::CFG_SPECIAL_FRAME:    cfg_special = value;
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [15:0] base, logic [7:0] rounds, logic [15:0] special);
        wait_idle();
        write_setting(rsib_pkg::CFG_BASE_SLEEP, base);
        write_setting(rsib_pkg::CFG_COLLISION_ROUNDS, {8'd0, rounds});
        write_setting(rsib_pkg::CFG_SPECIAL_FRAME, special);
    endtask

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        res_if.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Blink and undefined LED status, seed extremes, special mode, ignored op.
        push_req(rsib_pkg::OP_SLEEP, rsib_pkg::LED_SLOW, 1'b1, 16'hFFFF, 24'hFFFFFF);
        push_req(rsib_pkg::OP_SLEEP, LED_UNDEF, 1'b0, 16'h0000, 24'h000000);
        push_req(rsib_pkg::OP_SLEEP, rsib_pkg::LED_NORMAL, 1'b0, 16'h0000, 24'h000000);
        push_req(rsib_pkg::OP_SLEEP, rsib_pkg::LED_NORMAL, 1'b0, 16'hFFFF, 24'hFFFFFF);
        push_req(rsib_pkg::OP_SLEEP, rsib_pkg::LED_NORMAL, 1'b1, 16'h1234, 24'h000000);
        push_req(OP_IGNORED, LED_UNDEF, 1'b1, 16'hFFFF, 24'hFFFFFF);
        // A pending delay survives blink and special mode, a tiny margin falls back.
        push_req(rsib_pkg::OP_ARM_DELAY, rsib_pkg::LED_NORMAL, 1'b0, 16'h0000, 24'd0);
        push_req(rsib_pkg::OP_SLEEP, rsib_pkg::LED_FAST, 1'b0, 16'h0001, 24'd0);
        push_req(rsib_pkg::OP_SLEEP, rsib_pkg::LED_NORMAL, 1'b1, 16'h0002, 24'd0);
        push_req(rsib_pkg::OP_SLEEP, rsib_pkg::LED_NORMAL, 1'b0, 16'h0003, 24'd0);
        // Margins around the long-sleep limit.
        push_req(rsib_pkg::OP_ARM_DELAY, rsib_pkg::LED_NORMAL, 1'b0, 16'h0000, 24'hFFFFFF);
        push_req(rsib_pkg::OP_SLEEP, rsib_pkg::LED_NORMAL, 1'b0, 16'h0004, 24'd0);
        push_req(rsib_pkg::OP_ARM_DELAY, rsib_pkg::LED_NORMAL, 1'b0, 16'h0000, 24'd624450);
        push_req(rsib_pkg::OP_SLEEP, rsib_pkg::LED_NORMAL, 1'b0, 16'h0005, 24'd0);
        push_req(rsib_pkg::OP_ARM_DELAY, rsib_pkg::LED_NORMAL, 1'b0, 16'h0000, 24'd624451);
        push_req(rsib_pkg::OP_SLEEP, rsib_pkg::LED_NORMAL, 1'b0, 16'h0006, 24'd0);
        // Backoff from a large timer through to its end.
        push_req(rsib_pkg::OP_ARM_BACKOFF, rsib_pkg::LED_NORMAL, 1'b0, 16'h0000, 24'hFFFFFF);
        for (int i = 0; i < 10; i++) begin
            if (i == 3) begin
                push_req(rsib_pkg::OP_SLEEP, rsib_pkg::LED_SLOW, 1'b0, 16'($urandom), 24'd0);
            end else begin
                push_req(rsib_pkg::OP_SLEEP, rsib_pkg::LED_NORMAL, 1'b0, 16'($urandom),
                         24'd0);
            end
        end

        load_settings(16'h0000, 8'd0, 16'hFFFF);
        gen_traffic(250);

        // The round counter wraps without ending the backoff at the top setting.
        load_settings(16'hFFFF, 8'd255, 16'h0000);
        push_req(rsib_pkg::OP_ARM_BACKOFF, rsib_pkg::LED_NORMAL, 1'b0, 16'h0000, rand_load());
        repeat (270) push_req(rsib_pkg::OP_SLEEP, rsib_pkg::LED_NORMAL, 1'($urandom),
                              16'($urandom), 24'($urandom));
        gen_traffic(150);

        load_settings(16'd5, 8'd1, 16'($urandom));
        gen_traffic(250);

        load_settings(16'($urandom), 8'($urandom_range(2, 20)), 16'($urandom));
        gen_traffic(125);
        wait_idle();
        gen_traffic(125);

        load_settings(rsib_pkg::BASE_SLEEP_RST, rsib_pkg::COLLISION_ROUNDS_RST,
                      rsib_pkg::SPECIAL_FRAME_RST);
        gen_traffic(180);

        wait_idle();
        if (mismatch_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/rsib_pkg.sv
hdl/rsib_chan_if.sv
hdl/rsib_front.sv
hdl/rsib_queue.sv
hdl/rsib_back.sv
hdl/randomized_sleep_interval_backoff_unit.sv
verif/tb_top.sv
